>>> hdl/rtgb_pkg.sv
package rtgb_pkg;

  typedef enum logic [2:0] {
    DEC_IDLE   = 3'd0,
    DEC_BUDGET = 3'd1,
    DEC_NOTYET = 3'd2,
    DEC_BUSY   = 3'd3,
    DEC_TX     = 3'd4,
    DEC_FORCED = 3'd5,
    DEC_DONE   = 3'd6
  } dec_t;

  localparam logic OP_POLL = 1'b0;
  localparam logic OP_DONE = 1'b1;

  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_FACTOR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WINDOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MAXPKT  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PREAMB  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RETRY   = 3'd4;

  localparam logic [15:0] RST_FACTOR = 16'd256;
  localparam logic [31:0] RST_WINDOW = 32'd3600000;
  localparam logic [15:0] RST_RETRY  = 16'd200;
  // Cap for the reset window and factor: 3600000 * 256 / 512.
  localparam logic [31:0] RST_CAP    = 32'd1800000;

  localparam logic [17:0] LONG_FLOOR   = 18'd4000;
  localparam logic [17:0] LONG_CEIL    = 18'd12000;
  localparam logic [17:0] LONG_MARGIN  = 18'd250;
  localparam logic [17:0] SHORT_FLOOR  = 18'd400;
  localparam logic [17:0] SHORT_MARGIN = 18'd100;
  localparam logic [31:0] RESERVE      = 32'd100;
  localparam logic [1:0]  SHIFT_MAX    = 2'd2;

  // Dividend is the operand times 256, so 32 + 8 quotient bits.
  localparam int DivSteps = 40;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef struct packed {
    logic load;
    logic div_cap;
    logic div_ref;
    logic cap_load;
    logic apply;
    logic eval;
    logic lim;
    logic dec;
    logic mul;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

endpackage

>>> hdl/rtgb_div.sv
module rtgb_div
  import rtgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] x,
  input  logic [15:0] factor,
  output logic        done,
  output logic [31:0] q
);

  logic [39:0]        dvd_r, dvd_nxt;
  logic [16:0]        rem_r, rem_nxt;
  logic [16:0]        dvs_r;
  logic [DivCntW-1:0] cnt_r;
  logic               run_r, done_r;
  logic [17:0]        trial, diff;
  logic               ge;

  always_comb begin
    trial   = {rem_r, dvd_r[39]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[16:0] : trial[16:0];
    dvd_nxt = {dvd_r[38:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivSteps - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {x, 8'd0};
      rem_r <= '0;
      dvs_r <= {1'b0, factor} + 17'd256;
    end else if (run_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  // The quotient never exceeds the operand, so the low 32 bits hold it.
  assign q    = dvd_r[31:0];
  assign done = done_r;

endmodule

>>> hdl/rtgb_ctrl.sv
module rtgb_ctrl
  import rtgb_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  logic  cap_req,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CAP   = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_APPLY = 10'b00_0000_1000,
    S_EVAL  = 10'b00_0001_0000,
    S_LIM   = 10'b00_0010_0000,
    S_DEC   = 10'b00_0100_0000,
    S_MUL   = 10'b00_1000_0000,
    S_FIN   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   cap_pend_r, cap_pend_nxt;

  always_comb begin
    state_nxt    = state_r;
    cap_pend_nxt = cap_pend_r | cap_req;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cap_pend_r) begin
          cmd.div_cap  = 1'b1;
          cap_pend_nxt = cap_req;
          state_nxt    = S_CAP;
        end else if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.div_ref = 1'b1;
          state_nxt   = S_DIV;
        end
      end
      S_CAP: begin
        if (stat.div_done) begin
          cmd.cap_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.eval  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.lim   = 1'b1;
        state_nxt = S_LIM;
      end
      S_LIM: begin
        cmd.dec   = 1'b1;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.fin   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cap_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cap_pend_r <= cap_pend_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || cap_pend_r;
  assign out_valid = (state_r == S_OUT);

endmodule

>>> hdl/rtgb_dp.sv
module rtgb_dp
  import rtgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_operation,
  input  logic [31:0]        in_now_ms,
  input  logic               in_pending,
  input  logic               in_receiving,
  input  logic               in_mid_packet,
  input  logic [15:0]        in_est_airtime_ms,
  input  logic [15:0]        in_jitter_ms,
  output logic [2:0]         out_decision,
  output logic [31:0]        out_next_tx_ms,
  output logic [31:0]        out_budget_ms,
  output logic               out_cad_timeout
);

  logic [15:0] factor_r, maxpkt_r, preamb_r, retry_r;
  logic [31:0] window_r;

  logic        op_r, pend_r, recv_r, mid_r;
  logic [31:0] now_r;
  logic [15:0] est_r, jit_r;

  logic [31:0] budget_r, last_r, next_r, start_r, send_r, cap_r;
  logic        active_r, sticky_r, timeout_r;
  logic [1:0]  shift_r;
  logic [15:0] ejit_r;

  logic        busy_path_r, mul_pend_r;
  logic [31:0] mul_x_r, busy_age_r;
  logic [14:0] lim_r;
  logic [48:0] prod_r;
  dec_t        dec_r;

  logic [13:0] dl_long_r, dl_short_r;

  logic [31:0] div_x, div_q;
  logic        div_start;

  assign div_start = cmd.div_cap | cmd.div_ref;
  assign div_x     = cmd.div_cap ? window_r : (in_now_ms - last_r);

  rtgb_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .x      (div_x),
    .factor (factor_r),
    .done   (stat.div_done),
    .q      (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= RST_FACTOR;
      window_r <= RST_WINDOW;
      maxpkt_r <= '0;
      preamb_r <= '0;
      retry_r  <= RST_RETRY;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_FACTOR: factor_r <= cfg_wdata[15:0];
        REG_WINDOW: window_r <= cfg_wdata;
        REG_MAXPKT: maxpkt_r <= cfg_wdata[15:0];
        REG_PREAMB: preamb_r <= cfg_wdata[15:0];
        REG_RETRY:  retry_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Busy deadlines depend on configuration only and are refreshed every cycle.
  logic [17:0] lsum, ssum, long_v, sraw;
  always_comb begin
    lsum = {2'b0, maxpkt_r} + {5'b0, maxpkt_r[15:3]} + LONG_MARGIN;
    if (maxpkt_r == '0 || lsum < LONG_FLOOR) long_v = LONG_FLOOR;
    else if (lsum > LONG_CEIL)               long_v = LONG_CEIL;
    else                                     long_v = lsum;
    ssum = {1'b0, preamb_r, 1'b0} + SHORT_MARGIN;
    if (preamb_r == '0 || ssum < SHORT_FLOOR) sraw = SHORT_FLOOR;
    else                                      sraw = ssum;
    if (sraw > long_v) sraw = long_v;
  end

  always_ff @(posedge clk) begin
    dl_long_r  <= long_v[13:0];
    dl_short_r <= sraw[13:0];
  end

  logic [32:0] rsum;
  logic [31:0] half, dnext, tair;
  logic        passed;
  logic [13:0] lbase, jcap;
  logic        over;
  logic [17:0] bo;
  logic [14:0] left;
  logic [31:0] dly;

  always_comb begin
    rsum   = {1'b0, budget_r} + {1'b0, div_q};
    half   = {17'd0, est_r[15:1]};
    dnext  = now_r - next_r;
    passed = (dnext != '0) && !dnext[31];
    tair   = now_r - send_r;
    lbase  = sticky_r ? dl_long_r : dl_short_r;
    jcap   = (ejit_r > {3'd0, lbase[13:1]}) ? {1'b0, lbase[13:1]} : ejit_r[13:0];
    over   = busy_age_r > {17'd0, lim_r};
    bo     = {2'b0, retry_r} << shift_r;
    left   = lim_r - busy_age_r[14:0];
    if ({14'd0, bo} > {17'd0, left}) dly = (left != '0) ? {17'd0, left} : 32'd1;
    else                             dly = {14'd0, bo};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      now_r  <= in_now_ms;
      pend_r <= in_pending;
      recv_r <= in_receiving;
      mid_r  <= in_mid_packet;
      est_r  <= in_est_airtime_ms;
      jit_r  <= in_jitter_ms;
    end
    if (cmd.lim && busy_path_r) begin
      lim_r      <= {1'b0, lbase} + {1'b0, jcap};
      busy_age_r <= now_r - start_r;
    end
    if (cmd.mul) prod_r <= mul_x_r * ({1'b0, factor_r} + 17'd256);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= RST_CAP;
      cap_r       <= RST_CAP;
      last_r      <= '0;
      next_r      <= '0;
      start_r     <= '0;
      send_r      <= '0;
      active_r    <= 1'b0;
      sticky_r    <= 1'b0;
      timeout_r   <= 1'b0;
      shift_r     <= '0;
      ejit_r      <= '0;
      busy_path_r <= 1'b0;
      mul_pend_r  <= 1'b0;
      mul_x_r     <= '0;
      dec_r       <= DEC_IDLE;
    end else begin
      if (cmd.cap_load) cap_r <= div_q;
      // Refill is applied only when it adds at least one millisecond, and a poll
      // with nothing pending leaves the bucket alone.
      if (cmd.apply && div_q != '0 && (op_r == OP_DONE || pend_r)) begin
        budget_r <= (rsum > {1'b0, cap_r}) ? cap_r : rsum[31:0];
        last_r   <= now_r;
      end
      if (cmd.eval) begin
        busy_path_r <= 1'b0;
        mul_pend_r  <= 1'b0;
        if (op_r == OP_DONE) begin
          budget_r <= (tair > budget_r) ? '0 : budget_r - tair;
          dec_r    <= DEC_DONE;
        end else if (!pend_r) begin
          active_r <= 1'b0;
          dec_r    <= DEC_IDLE;
        end else if (budget_r < half) begin
          mul_x_r    <= half - budget_r;
          mul_pend_r <= 1'b1;
          active_r   <= 1'b0;
          dec_r      <= DEC_BUDGET;
        end else if (!passed) begin
          dec_r <= DEC_NOTYET;
        end else if (recv_r) begin
          busy_path_r <= 1'b1;
          if (!active_r) begin
            active_r <= 1'b1;
            start_r  <= now_r;
            shift_r  <= '0;
            sticky_r <= mid_r;
            ejit_r   <= jit_r;
          end else begin
            sticky_r <= sticky_r | mid_r;
          end
        end else begin
          active_r <= 1'b0;
          send_r   <= now_r;
          dec_r    <= DEC_TX;
        end
      end
      if (cmd.lim && op_r == OP_DONE) begin
        if (budget_r < RESERVE) begin
          mul_x_r    <= RESERVE - budget_r;
          mul_pend_r <= 1'b1;
        end else begin
          next_r <= now_r;
        end
      end
      if (cmd.dec && busy_path_r) begin
        if (over) begin
          timeout_r <= 1'b1;
          active_r  <= 1'b0;
          send_r    <= now_r;
          dec_r     <= DEC_FORCED;
        end else begin
          if (shift_r < SHIFT_MAX) shift_r <= shift_r + 1'b1;
          next_r <= now_r + dly;
          dec_r  <= DEC_BUSY;
        end
      end
      if (cmd.fin && mul_pend_r) next_r <= now_r + prod_r[39:8];
    end
  end

  assign out_decision    = dec_r;
  assign out_next_tx_ms  = next_r;
  assign out_budget_ms   = budget_r;
  assign out_cad_timeout = timeout_r;

endmodule

>>> hdl/radio_tx_gate_budget_backoff_unit.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   operation, now_ms, pending, receiving, ...
// out_     output     out_valid / out_stall decision, next_tx_ms, budget_ms, cad_timeout
// cfg_     input      cfg_we                cfg_idx, cfg_wdata
//
// Most of the time from an item's input beat to its result beat is spent in the 40-step
// serial divider by 256 plus the factor.
// One item is in flight; the next input beat is taken at the earliest in the cycle after
// the result beat. After a write to the factor or window register the divider recomputes
// the budget cap, with in_stall high. Reset is synchronous and active low.
module radio_tx_gate_budget_backoff_unit
  import rtgb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [31:0]        in_now_ms,
  input  logic               in_pending,
  input  logic               in_receiving,
  input  logic               in_mid_packet,
  input  logic [15:0]        in_est_airtime_ms,
  input  logic [15:0]        in_jitter_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_decision,
  output logic [31:0]        out_next_tx_ms,
  output logic [31:0]        out_budget_ms,
  output logic               out_cad_timeout
);

  cmd_t  cmd;
  stat_t stat;
  logic  cap_req;

  assign cap_req = cfg_we && (cfg_idx == REG_FACTOR || cfg_idx == REG_WINDOW);

  rtgb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cap_req   (cap_req),
    .stat      (stat),
    .cmd       (cmd)
  );

  rtgb_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_operation      (in_operation),
    .in_now_ms         (in_now_ms),
    .in_pending        (in_pending),
    .in_receiving      (in_receiving),
    .in_mid_packet     (in_mid_packet),
    .in_est_airtime_ms (in_est_airtime_ms),
    .in_jitter_ms      (in_jitter_ms),
    .out_decision      (out_decision),
    .out_next_tx_ms    (out_next_tx_ms),
    .out_budget_ms     (out_budget_ms),
    .out_cad_timeout   (out_cad_timeout)
  );

  // The input side is open only while no result is held.
  a_accept_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input open while a result is held");

  // The timeout flag never clears once set.
  a_timeout_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_cad_timeout |=> out_cad_timeout)
    else $error("timeout flag cleared");

  // A forced transmit always carries the timeout flag.
  a_forced_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_decision == DEC_FORCED) |-> out_cad_timeout)
    else $error("forced transmit without timeout flag");

endmodule
